### hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  // Fixed widths of the item fields.
  localparam int KEY_FW  = 32;
  localparam int STAT_FW = 2;
  localparam int FILL_FW = 7;

  // Operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // Status codes.
  localparam logic [STAT_FW-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_FW-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_FW-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              func;
    logic [KEY_FW-1:0] key;
  } spq_req_t;

  typedef struct packed {
    logic [KEY_FW-1:0]  popped_key;
    logic [STAT_FW-1:0] status;
    logic [FILL_FW-1:0] fill_count;
  } spq_rsp_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctrl_t;

endpackage

### hdl/spq_cell.sv
// One storage cell of the sorted key chain.
module spq_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                  clk,
  input  spq_pkg::spq_ctrl_t    ctrl,
  input  logic [KEY_WIDTH-1:0]  ins_key,
  input  logic                  valid,
  input  logic                  left_gt,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic [KEY_WIDTH-1:0]  right_key,
  output logic                  gt,
  output logic [KEY_WIDTH-1:0]  key
);
  import spq_pkg::*;

  logic [KEY_WIDTH-1:0] key_next;

  // An empty cell counts as holding a key above every other, so the
  // insertion point is the first cell whose flag is set.
  assign gt = !valid || (key > ins_key);

  always_comb begin
    key_next = key;
    priority if (ctrl.pop) begin
      key_next = right_key;
    end else if (ctrl.ins && gt) begin
      key_next = left_gt ? left_key : ins_key;
    end else begin
      key_next = key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue built from a chain of key cells.
//
//   Channel | Valid      | Stall      | Payload          | Direction
//   --------+------------+------------+------------------+----------
//   request | req_valid  | req_stall  | req (spq_req_t)  | in
//   result  | rsp_valid  | rsp_stall  | rsp (spq_rsp_t)  | out
//
// One item is taken per cycle while no result is stalled: every cell
// compares its key against the incoming key in parallel and shifts by at
// most one place, so an insert or a pop is done as the keys are registered.
// Its result is registered and appears in the cycle after it is accepted.
// Reset clears the fill count and the result valid flag; the cell keys are
// left as they are, since only cells below the fill count are ever read.
// A stalled result holds the request side as well: req_stall follows a
// waiting result that is being stalled.
module sorted_priority_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  spq_pkg::spq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output spq_pkg::spq_rsp_t rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                 accept;
  logic                 full;
  logic                 empty;
  spq_ctrl_t            ctrl;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [KEY_WIDTH-1:0] ins_key;
  logic [KEY_FW-1:0]    head_key;
  logic                 rsp_valid_next;
  spq_rsp_t             rsp_next;

  // Width adaption between the fixed item fields and the parameterised
  // internal key and count widths.
  logic [KEY_WIDTH+KEY_FW-1:0] ins_ext;
  logic [KEY_WIDTH+KEY_FW-1:0] head_ext;
  logic [CW+FILL_FW-1:0]       fill_ext;

  logic [CAPACITY-1:0]                gt;
  logic [CAPACITY-1:0][KEY_WIDTH-1:0] cell_key;

  // The request side waits only while a finished result is being held.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  assign ctrl.ins = accept && (req.func == FUNC_INSERT) && !full;
  assign ctrl.pop = accept && (req.func == FUNC_POP) && !empty;

  assign ins_ext  = {{KEY_WIDTH{1'b0}}, req.key};
  assign ins_key  = ins_ext[KEY_WIDTH-1:0];
  assign head_ext = {{KEY_FW{1'b0}}, cell_key[0]};
  assign head_key = head_ext[KEY_FW-1:0];

  // The chain of cells. Each cell sees its left neighbour's flag and key
  // for an insert and its right neighbour's key for a pop.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 left_gt;
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_key = ins_key;
    end else begin : g_inner
      assign left_gt  = gt[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_key   (ins_key),
      .valid     (CW'(i) < count),
      .left_gt   (left_gt),
      .left_key  (left_key),
      .right_key (right_key),
      .gt        (gt[i]),
      .key       (cell_key[i])
    );
  end

  always_comb begin
    count_next = count;
    priority if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  assign fill_ext = {{FILL_FW{1'b0}}, count_next};

  // The result of an accepted item is formed here and registered.
  always_comb begin
    rsp_next            = rsp;
    rsp_next.fill_count = fill_ext[FILL_FW-1:0];
    rsp_next.popped_key = '0;
    rsp_next.status     = ST_OK;
    unique case (req.func)
      FUNC_INSERT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end
      end
      FUNC_POP: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.popped_key = head_key;
        end
      end
      default: rsp_next.status = ST_OK;
    endcase
  end

  assign rsp_valid_next = accept || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // A successful insert raises the fill count by one.
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not raise fill count");

  // A successful pop returns the head cell's key as it stood before.
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> rsp_valid && rsp.popped_key == $past(head_key))
    else $error("popped key is not the former head");

  // The result reports the same fill count as the register holds.
  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.fill_count == fill_ext[FILL_FW-1:0] || CW > FILL_FW
      || rsp.fill_count == FILL_FW'(count))
    else $error("reported fill count disagrees with register");

endmodule
